>>> sv/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg: shared types and codes of the pending acknowledgment table
// Command and event codes, one table entry, one result and the cell control.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_ACK      = 2'd1;
  localparam logic [1:0] CMD_NACK     = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  localparam logic [1:0] EV_ACKED     = 2'd0;
  localparam logic [1:0] EV_NACKED    = 2'd1;
  localparam logic [1:0] EV_TIMED_OUT = 2'd2;
  localparam logic [1:0] EV_REJECTED  = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] tmo;
    logic [15:0] left;
  } pat_entry_t;

  typedef struct packed {
    logic [1:0]  ev;
    logic [15:0] id;
    logic [15:0] tmo;
    logic [15:0] used;
  } pat_result_t;

  // step: pop cell 0 and shift the active row; keep: re-append the popped
  // entry at the tail of the active row; wr: append a new entry
  typedef struct packed {
    logic step;
    logic keep;
    logic wr;
  } pat_ctl_t;

endpackage

>>> sv/pending_ack_timeout_table.sv
// A register raises no result; a rejected register yields its result from the reject state once the output is free.
// Ack, nack and tick scan the n stored entries, popping one from cell 0 per cycle
// unless the scan stalls; no new command is taken until the scan is through.
// Results leave through one output register; the scan stalls when a result must be handed on while it is held.
// Reset (synchronous, active low) empties the table and clears the state, counters and valid flags;
// entry contents and the command and result data registers are left as they are.
// ----------------------------------------------------------------------------
// pending_ack_timeout_table: table of packets waiting for acknowledgment
// Entries live in a row of cells in insertion order; acks, nacks and ticks
// rotate the row once, dropping and reporting matching or expired entries.
// ----------------------------------------------------------------------------
module pending_ack_timeout_table
  import pat_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // packet_id, timeout_ms, elapsed_ms
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // result_id, timeout_value, time_used
  output logic [1:0]  out_tuser,  // event_res
  output logic        out_tlast
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_REJ, ST_FLUSH} state_t;

  state_t      state_r,  state_nxt;
  logic [1:0]  cmd_r,    cmd_nxt;
  logic [15:0] pid_r,    pid_nxt;
  logic [15:0] tmo_r,    tmo_nxt;
  logic [15:0] ela_r,    ela_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rem_r,   rem_nxt;
  logic        pend_v_r, pend_v_nxt;
  pat_result_t pend_r,   pend_nxt;
  logic        out_v_r,  out_v_nxt;
  pat_result_t out_r,    out_nxt;
  logic        last_r,   last_nxt;

  pat_entry_t  cell_q [TABLE_DEPTH];
  pat_entry_t  head;
  pat_entry_t  head_kept;
  pat_entry_t  new_ent;
  pat_entry_t  bcast;
  pat_ctl_t    ctl;
  pat_result_t hit_res;

  logic in_fire;
  logic out_free;
  logic remove;
  logic step_go;
  logic is_tick;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_v_r || out_tready;

  assign head    = cell_q[0];
  assign is_tick = (cmd_r == CMD_TICK);
  assign remove  = is_tick ? (head.left <= ela_r) : (head.id == pid_r);
  assign step_go = (state_r == ST_SCAN) && !(remove && pend_v_r && !out_free);

  always_comb begin
    head_kept = head;
    if (is_tick) begin
      head_kept.left = head.left - ela_r;
    end
  end

  always_comb begin
    hit_res.id  = head.id;
    hit_res.tmo = head.tmo;
    if (is_tick) begin
      hit_res.ev   = EV_TIMED_OUT;
      hit_res.used = '0;
    end else begin
      hit_res.ev   = (cmd_r == CMD_ACK) ? EV_ACKED : EV_NACKED;
      hit_res.used = head.tmo - head.left;
    end
  end

  assign new_ent.id   = in_tdata[15:0];
  assign new_ent.tmo  = in_tdata[31:16];
  assign new_ent.left = in_tdata[31:16];

  assign ctl.wr   = in_fire && (in_tuser == CMD_REGISTER) && (count_r < DEPTH_C);
  assign ctl.step = step_go;
  assign ctl.keep = !remove;
  assign bcast    = ctl.wr ? new_ent : head_kept;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pat_entry_t nbr;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nbr = cell_q[i];
    end else begin : g_body
      assign nbr = cell_q[i + 1];
    end
    pat_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .len   (count_r),
      .nbr   (nbr),
      .bcast (bcast),
      .q     (cell_q[i])
    );
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    pid_nxt    = pid_r;
    tmo_nxt    = tmo_r;
    ela_nxt    = ela_r;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && !out_tready;
    out_nxt    = out_r;
    last_nxt   = last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_tuser;
          pid_nxt = in_tdata[15:0];
          tmo_nxt = in_tdata[31:16];
          ela_nxt = in_tdata[47:32];
          if (in_tuser == CMD_REGISTER) begin
            if (count_r < DEPTH_C) begin
              count_nxt = count_r + ONE_C;
            end else begin
              state_nxt = ST_REJ;
            end
          end else if (count_r != '0) begin
            rem_nxt   = count_r;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (step_go) begin
          rem_nxt = rem_r - ONE_C;
          if (remove) begin
            count_nxt = count_r - ONE_C;
            // hand the held result on; only the final one carries tlast
            if (pend_v_r) begin
              out_v_nxt = 1'b1;
              out_nxt   = pend_r;
              last_nxt  = 1'b0;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = hit_res;
          end
          if (rem_r == ONE_C) begin
            state_nxt = (remove || pend_v_r) ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_REJ: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_nxt   = '{ev: EV_REJECTED, id: pid_r, tmo: tmo_r, used: 16'd0};
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_v_nxt  = 1'b1;
          out_nxt    = pend_r;
          last_nxt   = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      rem_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rem_r    <= rem_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    cmd_r  <= cmd_nxt;
    pid_r  <= pid_nxt;
    tmo_r  <= tmo_nxt;
    ela_r  <= ela_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.used, out_r.tmo, out_r.id};
  assign out_tuser  = out_r.ev;
  assign out_tlast  = last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count beyond table depth");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((rem_r != '0) && (rem_r <= count_r)))
    else $error("scan counter out of range");

  a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> ((state_r == ST_SCAN) || (state_r == ST_FLUSH)))
    else $error("held result outside a scan");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FLUSH) && out_free) |=> (out_tvalid && out_tlast && !pend_v_r))
    else $error("final result not delivered with tlast");
`endif

endmodule

>>> sv/pat_cell.sv
// ----------------------------------------------------------------------------
// pat_cell: one slot of the pending table
// Holds one entry; takes its right neighbour's entry while the row shifts,
// or the broadcast entry when it is the tail of the active row or the free slot that a write fills.
// ----------------------------------------------------------------------------
module pat_cell
  import pat_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic          clk,
  input  pat_ctl_t      ctl,
  input  logic [CW-1:0] len,
  input  pat_entry_t    nbr,
  input  pat_entry_t    bcast,
  output pat_entry_t    q
);

  localparam logic [CW-1:0] POS  = CW'(IDX);
  localparam logic [CW-1:0] POS1 = CW'(IDX + 1);

  pat_entry_t ent_r;
  pat_entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.wr && (len == POS)) begin
      ent_nxt = bcast;
    end else if (ctl.step) begin
      if (POS1 < len) begin
        ent_nxt = nbr;
      end else if ((POS1 == len) && ctl.keep) begin
        ent_nxt = bcast;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign q = ent_r;

endmodule

>>> dv/pat_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pat_checker: scoreboard of the pending acknowledgment table
// Watches both stream channels, keeps its own copy of the table, works out
// the events that each accepted command must raise and compares every
// result beat, field by field, with the oldest outstanding event.
// ----------------------------------------------------------------------------
module pat_checker
  import pat_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // packet_id, timeout_ms, elapsed_ms
  input  logic [1:0]  in_tuser,   // command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // result_id, timeout_value, time_used
  input  logic [1:0]  out_tuser,  // event_res
  input  logic        out_tlast,
  output int          n_outstanding,
  output int          n_failed
);

  typedef struct {
    pat_result_t res;
    logic        last;
  } event_beat_t;

  logic [15:0] pend_id   [TABLE_DEPTH];
  logic [15:0] pend_tmo  [TABLE_DEPTH];
  logic [15:0] pend_left [TABLE_DEPTH];
  int          pend_count;

  event_beat_t owed_events[$];
  int          fail_total = 0;
  int          owed_total = 0;

  assign n_failed      = fail_total;
  assign n_outstanding = owed_total;

  task automatic report_mismatch(input string msg);
    if (fail_total < 40) $display("mismatch at %0t: %s", $realtime, msg);
    fail_total++;
  endtask

  function automatic event_beat_t make_event(input logic [1:0] ev, input logic [15:0] id,
                                             input logic [15:0] tmo, input logic [15:0] used);
    event_beat_t b;
    b.res.ev   = ev;
    b.res.id   = id;
    b.res.tmo  = tmo;
    b.res.used = used;
    b.last     = 1'b0;
    return b;
  endfunction

  // Apply one command to the shadow table and queue the events it raises.
  task automatic apply_command(input logic [1:0] cmd, input logic [15:0] pid,
                               input logic [15:0] tmo, input logic [15:0] elapsed);
    event_beat_t raised[$];
    logic [1:0]  ev;
    int          w;
    w = 0;
    case (cmd)
      CMD_REGISTER: begin
        if (pend_count >= TABLE_DEPTH) begin
          raised.insert(raised.size(), make_event(EV_REJECTED, pid, tmo, 16'd0));
        end else begin
          pend_id[pend_count]   = pid;
          pend_tmo[pend_count]  = tmo;
          pend_left[pend_count] = tmo;
          pend_count++;
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < pend_count; i++) begin
          if (pend_left[i] <= elapsed) begin
            raised.insert(raised.size(),
                          make_event(EV_TIMED_OUT, pend_id[i], pend_tmo[i], 16'd0));
          end else begin
            pend_id[w]   = pend_id[i];
            pend_tmo[w]  = pend_tmo[i];
            pend_left[w] = pend_left[i] - elapsed;
            w++;
          end
        end
        pend_count = w;
      end
      default: begin
        ev = (cmd == CMD_ACK) ? EV_ACKED : EV_NACKED;
        for (int i = 0; i < pend_count; i++) begin
          if (pend_id[i] == pid) begin
            raised.insert(raised.size(), make_event(ev, pend_id[i], pend_tmo[i],
                                                    pend_tmo[i] - pend_left[i]));
          end else begin
            pend_id[w]   = pend_id[i];
            pend_tmo[w]  = pend_tmo[i];
            pend_left[w] = pend_left[i];
            w++;
          end
        end
        pend_count = w;
      end
    endcase
    if (raised.size() > 0) raised[raised.size() - 1].last = 1'b1;
    foreach (raised[k]) owed_events.insert(owed_events.size(), raised[k]);
  endtask

  // Retire the result beat before taking the command beat of the same edge.
  always @(posedge clk) begin
    event_beat_t want;
    if (!rst_n) begin
      pend_count = 0;
      owed_events.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_events.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing owed: ev %0d data %h last %b",
                                    out_tuser, out_tdata, out_tlast));
        end else begin
          want = owed_events.pop_front();
          if (out_tuser !== want.res.ev)
            report_mismatch($sformatf("event_res %0d, want %0d", out_tuser, want.res.ev));
          if (out_tdata[15:0] !== want.res.id)
            report_mismatch($sformatf("result_id %h, want %h", out_tdata[15:0], want.res.id));
          if (out_tdata[31:16] !== want.res.tmo)
            report_mismatch($sformatf("timeout_value %h, want %h", out_tdata[31:16],
                                      want.res.tmo));
          if (out_tdata[47:32] !== want.res.used)
            report_mismatch($sformatf("time_used %h, want %h", out_tdata[47:32],
                                      want.res.used));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_tlast, want.last));
        end
      end
      if (in_tvalid && in_tready)
        apply_command(in_tuser, in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]);
    end
    owed_total = owed_events.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the pending acknowledgment table
// Drives a directed run over the corner cases, then random command streams
// under four patterns of input gaps and output stalls; the checker beside the block scores it.
// ----------------------------------------------------------------------------
module tb_top
  import pat_pkg::*;
();

  localparam int TABLE_DEPTH   = 16;
  localparam int ITEMS_A_PHASE = 90;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // packet_id, timeout_ms, elapsed_ms
  logic [1:0]  in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // result_id, timeout_value, time_used
  logic [1:0]  out_tuser;  // event_res
  logic        out_tlast;

  int          n_outstanding;
  int          n_failed;
  int          gap_pct;
  int          stall_pct;
  logic [15:0] id_pool [8];

  pending_ack_timeout_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  pat_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .n_outstanding(n_outstanding),
    .n_failed     (n_failed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Present one command beat and hold it until accepted.
  task automatic send_command(input logic [1:0] cmd, input logic [15:0] pid,
                              input logic [15:0] tmo, input logic [15:0] elapsed);
    @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {elapsed, tmo, pid};
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly pooled ids and short timeouts, so acks hit and ticks expire entries.
  task automatic send_random_command();
    int          r;
    logic [1:0]  cmd;
    logic [15:0] pid;
    logic [15:0] tmo;
    logic [15:0] elapsed;
    r = $urandom_range(99);
    if (r < 45)      cmd = CMD_REGISTER;
    else if (r < 60) cmd = CMD_ACK;
    else if (r < 70) cmd = CMD_NACK;
    else             cmd = CMD_TICK;
    pid = ($urandom_range(99) < 80) ? id_pool[$urandom_range(7)] : 16'($urandom);
    tmo = ($urandom_range(99) < 85) ? 16'($urandom_range(300)) : 16'($urandom);
    r = $urandom_range(99);
    if (r < 80)      elapsed = 16'($urandom_range(120));
    else if (r < 95) elapsed = 16'($urandom);
    else             elapsed = 16'd0;
    send_command(cmd, pid, tmo, elapsed);
  endtask

  initial begin
    int phase_gap   [4] = '{0, 65, 0, 10};
    int phase_stall [4] = '{0, 0, 65, 10};
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_REGISTER;
    gap_pct    = 0;
    stall_pct  = 0;
    foreach (id_pool[k]) id_pool[k] = 16'($urandom);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ack with nothing stored, zero timeout, duplicate ids, exact expiry
    send_command(CMD_ACK,      16'h5555, 16'($urandom), 16'($urandom));
    send_command(CMD_REGISTER, 16'h0000, 16'h0000, 16'($urandom));
    send_command(CMD_REGISTER, 16'hffff, 16'hffff, 16'($urandom));
    send_command(CMD_REGISTER, 16'h1234, 16'd100,  16'($urandom));
    send_command(CMD_REGISTER, 16'h1234, 16'd50,   16'($urandom));
    send_command(CMD_TICK,     16'($urandom), 16'($urandom), 16'd0);
    send_command(CMD_TICK,     16'($urandom), 16'($urandom), 16'd30);
    send_command(CMD_TICK,     16'($urandom), 16'($urandom), 16'd20);
    send_command(CMD_ACK,      16'h1234, 16'($urandom), 16'($urandom));
    send_command(CMD_NACK,     16'hffff, 16'($urandom), 16'($urandom));
    // fill the table, overflow it, then expire every entry at once
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_command(CMD_REGISTER, 16'($urandom), 16'($urandom), 16'($urandom));
    send_command(CMD_REGISTER, 16'hffff, 16'hffff, 16'h0000);
    send_command(CMD_TICK,     16'($urandom), 16'($urandom), 16'hffff);

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];
      repeat (ITEMS_A_PHASE) send_random_command();
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    gap_pct   = 0;
    stall_pct = 0;

    while (n_outstanding != 0) @(negedge clk);
    repeat (TABLE_DEPTH + 8) @(negedge clk);
    if (n_failed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/pat_pkg.sv
sv/pat_cell.sv
sv/pending_ack_timeout_table.sv
dv/pat_checker.sv
dv/tb_top.sv
